[rtl/bpk_pkg.sv]
// Package with the shared types and constants of the byte packetizer.
`default_nettype none

package bpk_pkg;

   // Command carried on the request side.
   typedef enum logic [1:0] {
      CMD_DATA  = 2'd0,
      CMD_TICK  = 2'd1,
      CMD_ENTER = 2'd2
   } cmd_type;

   // Kind of a response word.
   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_PKT_END = 2'd1,
      KIND_ESCAPE  = 2'd2
   } kind_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_PACKET_LIMIT = 2'd0,
      CSR_PACK_TIME    = 2'd1,
      CSR_GUARD        = 2'd2
   } csr_index_type;

   localparam int LenW = 11;
   localparam int TickW = 16;
   localparam int ChunkCntW = 3;

   localparam logic [7:0]           PlusChar      = 8'h2B;
   localparam logic [ChunkCntW-1:0] EscapeLen     = 3'd3;
   localparam logic [ChunkCntW-1:0] ChunkCntMax   = 3'd7;
   localparam logic [TickW-1:0]     TickMax       = 16'hFFFF;

   localparam logic [LenW-1:0]  PacketLimitRst = 11'd256;
   localparam logic [TickW-1:0] PackTimeRst    = 16'd100;
   localparam logic [TickW-1:0] GuardRst       = 16'd1000;

   typedef struct packed {
      kind_type        kind;
      logic [7:0]      out_byte;
      logic [LenW-1:0] length;
   } result_type;

endpackage

`default_nettype wire

[rtl/bpk_rsp_queue.sv]
// Four-entry response queue that takes up to two words a cycle and gives one.
`default_nettype none

module bpk_rsp_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push0,
   input  wire                  push1,
   input  bpk_pkg::result_type  data0,
   input  bpk_pkg::result_type  data1,
   output logic                 room,
   output logic                 out_valid,
   input  wire                  out_ready,
   output bpk_pkg::result_type  out_data
);
   import bpk_pkg::*;

   localparam int Depth = 4;
   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);

   result_type            entries_ff [Depth];
   logic [PtrW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]       count_ff, count_in;
   logic                  pop;
   logic [PtrW-1:0]       wr_ptr_next;
   logic [CntW-1:0]       push_n;

   assign pop         = out_valid && out_ready;
   assign wr_ptr_next = wr_ptr_ff + PtrW'(1);
   assign push_n      = CntW'(push0) + CntW'(push1);

   assign room      = count_ff <= CntW'(Depth - 2);
   assign out_valid = count_ff != '0;
   assign out_data  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PtrW'(push_n);
      rd_ptr_in = pop ? rd_ptr_ff + PtrW'(1) : rd_ptr_ff;
      count_in  = count_ff + push_n - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push0) begin
         entries_ff[wr_ptr_ff] <= data0;
      end
      if (push1) begin
         entries_ff[wr_ptr_next] <= data1;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("response queue count beyond depth");

   a_push_order: assert property (@(posedge clock) disable iff (reset)
      push1 |-> push0)
      else $error("second word pushed without the first");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push0 |-> room)
      else $error("push into a queue without room for two words");
`endif

endmodule

`default_nettype wire

[rtl/byte_packetizer_with_guard_escape_unit.sv]
// Top level of the byte packetizer with guarded "+++" escape detection.
//
// Request channel (req_*): one word per host byte, timer tick or enter
// command; req_tuser carries the command and the chunk start mark, req_tlast
// marks the last byte of a received chunk. Response channel (rsp_*): payload
// bytes, packet ends with their length, and the escape word with the number
// of discarded bytes. Configuration channel (csr_*): always ready, writes the
// packet limit, pack time and guard time; it is used while the block is idle.
//
// Each accepted request is decoded and its state update done in the same
// cycle; its one or two response words land in a four-entry response queue
// and the first is offered on rsp_* the next cycle when the queue was empty.
// A new request is taken every cycle as long as the queue has room for two
// words, so the rate is one request per cycle, bounded by the response port
// giving one word per cycle: a byte that closes a packet yields two words.
//
// Reset restores the register defaults, puts the block in transport mode and
// empties the queue. When the receiver stalls, words stay in the queue and
// req_tready drops once fewer than two free entries remain.
`default_nettype none

module byte_packetizer_with_guard_escape_unit #(
   parameter int MAX_PACKET = 1024
) (
   input  wire         clock,
   input  wire         reset,
   // Request channel.
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] data_byte
   input  wire  [2:0]  req_tuser,   // [1:0] cmd, [2] chunk_start
   input  wire         req_tlast,   // chunk_end
   // Response channel.
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] out_byte, [18:8] length, rest zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   // Configuration channel.
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [1:0]  csr_index,
   input  wire  [15:0] csr_wdata
);
   import bpk_pkg::*;

   localparam logic [12:0] MaxPacketW = 13'(MAX_PACKET);

   // Configuration registers.
   logic [LenW-1:0]      packet_limit_ff;
   logic [TickW-1:0]     pack_time_ff;
   logic [TickW-1:0]     guard_ff;

   // Transport state.
   logic                 active_ff, active_in;
   logic                 armed_ff, armed_in;
   logic                 chunk_ready_ff, chunk_ready_in;
   logic [ChunkCntW-1:0] chunk_cnt_ff, chunk_cnt_in;
   logic                 all_plus_ff, all_plus_in;
   logic [TickW-1:0]     idle_ff, idle_in;
   logic [LenW-1:0]      pending_ff, pending_in;

   logic                 accept;
   cmd_type              cmd;
   logic [7:0]           data_byte;
   logic                 chunk_start;
   logic                 chunk_end;
   logic [LenW-1:0]      limit_eff;
   logic [ChunkCntW-1:0] cnt_base;
   logic [ChunkCntW-1:0] cnt_new;
   logic                 ready_new;
   logic                 plus_new;
   logic [LenW-1:0]      pending_inc;
   logic [TickW-1:0]     idle_inc;

   logic                 push0, push1;
   result_type           res0, res1, head;
   logic                 room;

   assign accept      = req_tvalid && req_tready;
   assign cmd         = cmd_type'(req_tuser[1:0]);
   assign chunk_start = req_tuser[2];
   assign chunk_end   = req_tlast;
   assign data_byte   = req_tdata;
   assign req_tready  = room;
   assign csr_ready   = 1'b1;

   // Out-of-range packet limits clamp to one and to the maximum packet size.
   always_comb begin
      if (packet_limit_ff == '0) begin
         limit_eff = LenW'(1);
      end else if ({2'b00, packet_limit_ff} > MaxPacketW) begin
         limit_eff = MaxPacketW[LenW-1:0];
      end else begin
         limit_eff = packet_limit_ff;
      end
   end

   // Chunk tracking for a data byte: a chunk start restarts the counters and
   // samples whether enough silence came before it.
   assign cnt_base    = chunk_start ? '0 : chunk_cnt_ff;
   assign cnt_new     = (cnt_base < ChunkCntMax) ? cnt_base + ChunkCntW'(1) : ChunkCntMax;
   assign ready_new   = chunk_start ? (idle_ff >= guard_ff) : chunk_ready_ff;
   assign plus_new    = (chunk_start || all_plus_ff) && (data_byte == PlusChar);
   assign pending_inc = pending_ff + LenW'(1);
   assign idle_inc    = (idle_ff == TickMax) ? idle_ff : idle_ff + TickW'(1);

   always_comb begin
      active_in      = active_ff;
      armed_in       = armed_ff;
      chunk_ready_in = chunk_ready_ff;
      chunk_cnt_in   = chunk_cnt_ff;
      all_plus_in    = all_plus_ff;
      idle_in        = idle_ff;
      pending_in     = pending_ff;
      push0          = 1'b0;
      push1          = 1'b0;
      res0           = '{kind: KIND_PAYLOAD, out_byte: data_byte, length: '0};
      res1           = '{kind: KIND_PKT_END, out_byte: '0, length: pending_inc};

      if (accept) begin
         case (cmd)
            CMD_ENTER: begin
               active_in      = 1'b1;
               armed_in       = 1'b0;
               chunk_ready_in = 1'b0;
               chunk_cnt_in   = '0;
               all_plus_in    = 1'b1;
               idle_in        = '0;
               pending_in     = '0;
            end
            CMD_DATA: begin
               if (active_ff) begin
                  idle_in      = '0;
                  chunk_cnt_in = cnt_new;
                  all_plus_in  = plus_new;
                  if (chunk_end) begin
                     // Exactly three plus signs after a guard silence arm it.
                     armed_in       = ready_new && (cnt_new == EscapeLen) && plus_new;
                     chunk_ready_in = 1'b0;
                  end else begin
                     armed_in       = 1'b0;
                     chunk_ready_in = ready_new;
                  end
                  push0 = 1'b1;
                  if (pending_inc >= limit_eff) begin
                     push1      = 1'b1;
                     pending_in = '0;
                  end else begin
                     pending_in = pending_inc;
                  end
               end
            end
            CMD_TICK: begin
               if (active_ff) begin
                  idle_in = idle_inc;
                  if (armed_ff && (idle_inc >= guard_ff)) begin
                     // Escape fires: pending bytes are reported and dropped.
                     res0       = '{kind: KIND_ESCAPE, out_byte: '0, length: pending_ff};
                     push0      = 1'b1;
                     pending_in = '0;
                     armed_in   = 1'b0;
                     active_in  = 1'b0;
                  end else if ((pending_ff != '0) && (idle_inc > pack_time_ff)) begin
                     res0       = '{kind: KIND_PKT_END, out_byte: '0, length: pending_ff};
                     push0      = 1'b1;
                     pending_in = '0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff      <= 1'b1;
         armed_ff       <= 1'b0;
         chunk_ready_ff <= 1'b0;
         chunk_cnt_ff   <= '0;
         all_plus_ff    <= 1'b1;
         idle_ff        <= '0;
         pending_ff     <= '0;
      end else begin
         active_ff      <= active_in;
         armed_ff       <= armed_in;
         chunk_ready_ff <= chunk_ready_in;
         chunk_cnt_ff   <= chunk_cnt_in;
         all_plus_ff    <= all_plus_in;
         idle_ff        <= idle_in;
         pending_ff     <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         packet_limit_ff <= PacketLimitRst;
         pack_time_ff    <= PackTimeRst;
         guard_ff        <= GuardRst;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_PACKET_LIMIT: packet_limit_ff <= csr_wdata[LenW-1:0];
            CSR_PACK_TIME:    pack_time_ff    <= csr_wdata;
            CSR_GUARD:        guard_ff        <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   bpk_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push0     (push0),
      .push1     (push1),
      .data0     (res0),
      .data1     (res1),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (head)
   );

   assign rsp_tdata = {5'b00000, head.length, head.out_byte};
   assign rsp_tuser = head.kind;

`ifndef ASSERT_OFF
   a_armed_active: assert property (@(posedge clock) disable iff (reset)
      armed_ff |-> active_ff)
      else $error("escape armed while in command mode");

   a_enter_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && (cmd == CMD_ENTER)) |=> (active_ff && !armed_ff && (pending_ff == '0)))
      else $error("enter command did not restore transport mode");

   a_escape_stops: assert property (@(posedge clock) disable iff (reset)
      (push0 && (res0.kind == KIND_ESCAPE)) |=> !active_ff)
      else $error("escape reported but block still active");
`endif

endmodule

`default_nettype wire

[test/byte_packetizer_with_guard_escape_unit_tb.sv]
// Self-checking testbench for the byte packetizer with guarded escape detection.
`timescale 1ns / 100ps

module byte_packetizer_with_guard_escape_unit_tb;
   import bpk_pkg::*;

   localparam int MaxPacket = 1024;
   // The index and command codes that the block has to ignore.
   localparam logic [1:0] CsrUnused = 2'd3;
   localparam logic [1:0] CmdUnused = 2'd3;
   // Length of the one long receiver hold-off, in clock cycles.
   localparam int HoldCycles = 90;
   // Cycles given to the block after the last expected word, before a register
   // write or the end of the run. Ticks and ignored words produce no response,
   // so the block may still be busy with one when the queue runs dry.
   localparam int SettleCycles = 4;
   // Random sequences per random phase; each is a few words long.
   localparam int PhaseSeqs = 24;

   // One request word as the host side sees it.
   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] data;
      logic       cstart;
      logic       cend;
   } host_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] data_byte
   logic [2:0]  req_tuser = '0;   // [1:0] cmd, [2] chunk_start
   logic        req_tlast = 1'b0; // chunk_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // [7:0] out_byte, [18:8] length
   logic [1:0]  rsp_tuser;        // [1:0] kind
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   byte_packetizer_with_guard_escape_unit #(
      .MAX_PACKET(MaxPacket)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Words waiting to be offered, and response words still owed by the block.
   host_word_type host_words[$];
   result_type    rsp_expected[$];
   int            mismatches = 0;

   // Idle and stall rates in percent per cycle; written by the stimulus process.
   int   req_idle_pct = 0;
   int   rsp_stall_pct = 0;
   logic hold_request = 1'b0;

   // Our copy of the registers, kept in step with every register write.
   logic [LenW-1:0]  cfg_limit = PacketLimitRst;
   logic [TickW-1:0] cfg_pack  = PackTimeRst;
   logic [TickW-1:0] cfg_guard = GuardRst;

   // Our copy of the link state.
   logic                 link_active;
   logic                 esc_armed;
   logic                 chunk_ok;
   logic [ChunkCntW-1:0] chunk_len;
   logic                 chunk_plus;
   logic [TickW-1:0]     quiet_ticks;
   logic [LenW-1:0]      held_len;

   host_word_type in_flight;
   int            req_gap = 0;
   int            hold_left = 0;
   int            stall_left = 0;
   logic          hold_served = 1'b0;
   result_type    rsp_next;

   initial begin
      forever #5 clock = ~clock;
   end

   // Back to transport mode with nothing pending; used by reset and by enter.
   task automatic clear_link;
      link_active = 1'b1;
      esc_armed   = 1'b0;
      chunk_ok    = 1'b0;
      chunk_len   = '0;
      chunk_plus  = 1'b1;
      quiet_ticks = '0;
      held_len    = '0;
   endtask

   // Applies one accepted request word to our link state and queues the
   // response words it must produce, in order.
   task automatic packetize_word(input host_word_type w);
      logic [LenW-1:0] limit;
      if (w.cmd == CMD_ENTER) begin
         // Enter always resets the link, even in the middle of a packet.
         clear_link();
      end else if (link_active && w.cmd == CMD_DATA) begin
         // Out-of-range limits are clamped to the sizes the block supports.
         limit = cfg_limit;
         if (limit == 0) limit = 1;
         if (limit > MaxPacket) limit = MaxPacket;
         // A chunk start judges the silence before it, then restarts the count.
         if (w.cstart) begin
            chunk_ok   = quiet_ticks >= cfg_guard;
            chunk_len  = '0;
            chunk_plus = 1'b1;
         end
         esc_armed   = 1'b0;
         quiet_ticks = '0;
         if (chunk_len != ChunkCntMax) chunk_len = chunk_len + 1'b1;
         if (w.data != PlusChar) chunk_plus = 1'b0;
         if (w.cend) begin
            if (chunk_ok && chunk_len == EscapeLen && chunk_plus) esc_armed = 1'b1;
            chunk_ok = 1'b0;
         end
         rsp_expected.push_back('{kind: KIND_PAYLOAD, out_byte: w.data, length: '0});
         held_len = held_len + 1'b1;
         if (held_len >= limit) begin
            rsp_expected.push_back('{kind: KIND_PKT_END, out_byte: '0, length: held_len});
            held_len = '0;
         end
      end else if (link_active && w.cmd == CMD_TICK) begin
         if (quiet_ticks != TickMax) quiet_ticks = quiet_ticks + 1'b1;
         // The escape wins over a packet end; pending bytes are thrown away.
         if (esc_armed && quiet_ticks >= cfg_guard) begin
            rsp_expected.push_back('{kind: KIND_ESCAPE, out_byte: '0, length: held_len});
            held_len    = '0;
            esc_armed   = 1'b0;
            link_active = 1'b0;
         end else if (held_len != 0 && quiet_ticks > cfg_pack) begin
            rsp_expected.push_back('{kind: KIND_PKT_END, out_byte: '0, length: held_len});
            held_len = '0;
         end
      end
   endtask

   task automatic queue_word(input logic [1:0] cmd, input logic [7:0] data,
                             input logic cstart, input logic cend);
      host_words.push_back('{cmd: cmd, data: data, cstart: cstart, cend: cend});
   endtask

   // Timer ticks carry junk in the unused fields; the block must not care.
   task automatic queue_ticks(input int count);
      for (int i = 0; i < count; i++)
         queue_word(CMD_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
   endtask

   // A chunk of host bytes. Marked chunks have start on the first byte and end
   // on the last; unmarked ones get their marks at random, so marks go missing
   // or land in the middle.
   task automatic queue_chunk(input int len, input bit plus_heavy, input bit marked);
      for (int i = 0; i < len; i++)
         queue_word(CMD_DATA,
                    (plus_heavy && $urandom_range(3) != 0) ? PlusChar : 8'($urandom),
                    marked ? (i == 0) : 1'($urandom),
                    marked ? (i == len - 1) : 1'($urandom));
   endtask

   // Holds the sender back until the block has delivered everything it owes.
   task automatic settle;
      do @(negedge clock);
      while (host_words.size() != 0 || req_tvalid || rsp_expected.size() != 0);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_PACKET_LIMIT: cfg_limit = value[LenW-1:0];
         CSR_PACK_TIME:    cfg_pack  = value;
         CSR_GUARD:        cfg_guard = value;
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Request driver. Every accepted word goes through the predictor at the
   // edge that accepts it. A new word is offered only once the previous one is
   // gone, and idle bursts are sprinkled in at random.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap    <= 0;
         clear_link();
      end else begin
         if (req_tvalid && req_tready) packetize_word(in_flight);
         if (!req_tvalid || req_tready) begin
            if (req_gap != 0) begin
               req_gap    <= req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (host_words.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
               req_gap    <= $urandom_range(10);
               req_tvalid <= 1'b0;
            end else begin
               in_flight = host_words.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= in_flight.data;
               req_tuser  <= {in_flight.cstart, in_flight.cmd};
               req_tlast  <= in_flight.cend;
            end
         end
      end
   end

   // Response monitor and ready driver. Each accepted word is checked field by
   // field against the oldest expectation. Ready is dropped in random bursts,
   // and once for a long hold-off so the block's queue fills and backs up.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rsp_expected.size() == 0) begin
            $display("%0t: unexpected response word, kind %0d byte 0x%02h length %0d",
                     $time, rsp_tuser, rsp_tdata[7:0], rsp_tdata[18:8]);
            mismatches++;
         end else begin
            rsp_next = rsp_expected.pop_front();
            if (rsp_tuser != rsp_next.kind) begin
               $display("%0t: kind mismatch, expected %0d, got %0d",
                        $time, rsp_next.kind, rsp_tuser);
               mismatches++;
            end
            if (rsp_tdata[7:0] != rsp_next.out_byte) begin
               $display("%0t: byte mismatch, expected 0x%02h, got 0x%02h",
                        $time, rsp_next.out_byte, rsp_tdata[7:0]);
               mismatches++;
            end
            if (rsp_tdata[18:8] != rsp_next.length) begin
               $display("%0t: length mismatch, expected %0d, got %0d",
                        $time, rsp_next.length, rsp_tdata[18:8]);
               mismatches++;
            end
         end
      end
      if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_request && !hold_served) begin
         hold_served <= 1'b1;
         hold_left   <= HoldCycles - 1;
         rsp_tready  <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_stall_pct != 0 && $urandom_range(99) < rsp_stall_pct) begin
         stall_left <= $urandom_range(10);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Stimulus: a directed opening, five random phases under different register
   // settings, and a final phase at the register extremes without any idling.
   initial begin
      int               ph;
      int               seq;
      int               pick;
      int               flaw;
      int               n;
      logic [15:0]      lim;
      logic [15:0]      pk;
      logic [15:0]      gd;
      int               ipct;
      int               spct;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part: small limits so every path shows up within a few words.
      write_reg(CSR_PACKET_LIMIT, 16'd4);
      write_reg(CSR_PACK_TIME, 16'd2);
      write_reg(CSR_GUARD, 16'd2);
      req_idle_pct  <= 20;
      rsp_stall_pct <= 20;
      // A one-byte chunk, then a packet closed by the limit with the byte extremes.
      queue_word(CMD_DATA, 8'h00, 1'b1, 1'b1);
      queue_word(CMD_DATA, 8'hFF, 1'b1, 1'b0);
      queue_word(CMD_DATA, 8'h55, 1'b0, 1'b0);
      queue_word(CMD_DATA, 8'hAA, 1'b0, 1'b1);
      // Guard silence, a clean escape chunk, and guard silence again.
      queue_ticks(3);
      queue_word(CMD_DATA, PlusChar, 1'b1, 1'b0);
      queue_word(CMD_DATA, PlusChar, 1'b0, 1'b0);
      queue_word(CMD_DATA, PlusChar, 1'b0, 1'b1);
      queue_ticks(2);
      // While in command mode, bytes, ticks and the unused command are dropped.
      queue_word(CMD_DATA, 8'h12, 1'b1, 1'b1);
      queue_ticks(1);
      queue_word(CmdUnused, 8'hC3, 1'b1, 1'b1);
      queue_word(CMD_ENTER, 8'h00, 1'b0, 1'b0);
      // A partial packet closed once the pack time is exceeded.
      queue_word(CMD_DATA, 8'h07, 1'b1, 1'b1);
      queue_ticks(3);
      queue_word(CmdUnused, 8'h3C, 1'b0, 1'b0);
      // Enter in transport mode drops the pending byte without a response.
      queue_word(CMD_DATA, 8'h80, 1'b0, 1'b0);
      queue_word(CMD_ENTER, 8'hFF, 1'b1, 1'b1);
      queue_ticks(3);
      settle();

      for (ph = 0; ph < 5; ph++) begin
         case (ph)
            0:       begin lim = 0;         pk = 0; gd = 1; ipct = 15; spct = 15; end
            1:       begin lim = MaxPacket; pk = 5; gd = 3; ipct = 0;  spct = 0;  end
            2:       begin lim = 7;         pk = 3; gd = 4; ipct = 30; spct = 30; end
            3:       begin lim = 3;         pk = 1; gd = 2; ipct = 10; spct = 40; end
            default: begin
               lim  = $urandom_range(12, 1);
               pk   = $urandom_range(6);
               gd   = $urandom_range(6, 1);
               ipct = 20;
               spct = 20;
            end
         endcase
         // A write to the unused index must leave every register alone.
         if (ph == 3) write_reg(CsrUnused, 16'($urandom));
         write_reg(CSR_PACKET_LIMIT, lim);
         write_reg(CSR_PACK_TIME, pk);
         write_reg(CSR_GUARD, gd);
         req_idle_pct  <= ipct;
         rsp_stall_pct <= spct;
         if (ph == 0) begin
            // With a limit of one every byte yields two words, so a long
            // hold-off on the response side backs the block up quickly. The
            // long chunk also runs the chunk counter into saturation.
            queue_chunk(12, 1'b0, 1'b1);
            hold_request <= 1'b1;
         end
         for (seq = 0; seq < PhaseSeqs; seq++) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
               queue_chunk($urandom_range(8, 1), $urandom_range(3) == 0,
                           $urandom_range(9) != 0);
            end else if (pick < 50) begin
               queue_ticks($urandom_range(cfg_pack + cfg_guard + 2, 1));
            end else if (pick < 78) begin
               // An escape attempt; about one in four is spoiled in some way:
               // short silence, wrong length, a stray character, no end mark,
               // or a byte that breaks the trailing silence.
               flaw = ($urandom_range(3) == 0) ? $urandom_range(5, 1) : 0;
               queue_ticks((flaw == 1) ? cfg_guard - 1 : cfg_guard + $urandom_range(2));
               n = (flaw == 2) ? ($urandom_range(1) ? 4 : 2) : 3;
               for (int i = 0; i < n; i++)
                  queue_word(CMD_DATA, (flaw == 3 && i == n - 1) ? PlusChar + 8'd1 : PlusChar,
                             i == 0, i == n - 1 && flaw != 4);
               if (flaw == 5) begin
                  queue_ticks(cfg_guard / 2);
                  queue_word(CMD_DATA, 8'($urandom), 1'b0, 1'b0);
               end
               queue_ticks(cfg_guard + $urandom_range(1));
               // Now and then a few words land while in command mode.
               if ($urandom_range(4) == 0) begin
                  queue_word(CMD_DATA, 8'($urandom), 1'($urandom), 1'($urandom));
                  queue_ticks(2);
               end
               if ($urandom_range(9) != 0)
                  queue_word(CMD_ENTER, 8'($urandom), 1'($urandom), 1'($urandom));
            end else if (pick < 86) begin
               queue_word(CMD_DATA, 8'($urandom), 1'($urandom), 1'($urandom));
            end else if (pick < 93) begin
               queue_word(CMD_ENTER, 8'($urandom), 1'($urandom), 1'($urandom));
            end else begin
               queue_word(CmdUnused, 8'($urandom), 1'($urandom), 1'($urandom));
            end
         end
         // The sender waits here until every owed word has come back.
         settle();
      end

      // Register extremes, no idling on either side. The limit field of all ones
      // clamps to the largest packet. With the widest pack time and guard time a
      // short silence closes nothing and the escape chunk cannot arm.
      write_reg(CSR_PACKET_LIMIT, 16'hFFFF);
      write_reg(CSR_PACK_TIME, TickMax - 16'd1);
      write_reg(CSR_GUARD, TickMax);
      req_idle_pct  <= 0;
      rsp_stall_pct <= 0;
      queue_chunk(16, 1'b0, 1'b1);
      queue_ticks(4);
      queue_word(CMD_DATA, PlusChar, 1'b1, 1'b0);
      queue_word(CMD_DATA, PlusChar, 1'b0, 1'b0);
      queue_word(CMD_DATA, PlusChar, 1'b0, 1'b1);
      queue_ticks(4);
      settle();

      // The narrowest pack time and guard time: one tick closes the packet held
      // over from above, and a single tick of silence guards the escape.
      write_reg(CSR_PACK_TIME, 16'd0);
      write_reg(CSR_GUARD, 16'd1);
      queue_ticks(1);
      queue_word(CMD_DATA, PlusChar, 1'b1, 1'b0);
      queue_word(CMD_DATA, PlusChar, 1'b0, 1'b0);
      queue_word(CMD_DATA, PlusChar, 1'b0, 1'b1);
      queue_ticks(1);
      queue_word(CMD_ENTER, 8'h00, 1'b0, 1'b0);
      settle();

      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog: a correct run takes well under 2 ms of simulated time.
   initial begin
      #10_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

[filelist.f]
rtl/bpk_pkg.sv
rtl/bpk_rsp_queue.sv
rtl/byte_packetizer_with_guard_escape_unit.sv
test/byte_packetizer_with_guard_escape_unit_tb.sv
